@@ hw/rtl/i2cmra_pkg.sv @@
// shared types and constants of the i2c master register access unit
package i2cmra_pkg;

    // request codes of an input item
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // register indexes of the configuration port
    localparam logic REG_DEVICE_ADDRESS      = 1'b0;
    localparam logic REG_READ_START_REGISTER = 1'b1;

    localparam logic [6:0] DEVICE_ADDRESS_RESET      = 7'd30;
    localparam logic [7:0] READ_START_REGISTER_RESET = 8'd3;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_START  = 4'd1,
        ST_ADDR_W = 4'd2,
        ST_REG    = 4'd3,
        ST_DATA   = 4'd4,
        ST_RSTART = 4'd5,
        ST_ADDR_R = 4'd6,
        ST_RECV   = 4'd7,
        ST_STOP   = 4'd8
    } t_step;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_data;
        logic [3:0] read_index;
        logic       done_res;
    } t_out_item;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] read_start_register;
    } t_cfg;

endpackage

@@ hw/rtl/i2cmra_seq.sv @@
// bus phase sequencer: holds the transaction state and works out one phase per tick item
module i2cmra_seq #(
    parameter int READ_BYTES = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  i2cmra_pkg::t_in_item  i_item,
    input  i2cmra_pkg::t_cfg      i_cfg,
    output i2cmra_pkg::t_out_item o_res
);

    localparam logic [3:0] LastByte = 4'(READ_BYTES - 1);

    i2cmra_pkg::t_step r_step, n_step;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_bit, n_bit;
    logic [3:0] r_byte, n_byte;
    logic [7:0] r_shift, n_shift;
    logic       r_is_read, n_is_read;
    logic [7:0] r_held_addr, n_held_addr;
    logic [7:0] r_held_data, n_held_data;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;

    logic              last_phase;
    logic              go;
    i2cmra_pkg::t_step go_target;
    logic              rd_valid;
    logic [7:0]        rd_data;
    logic [3:0]        rd_index;
    logic              done;
    logic              last_byte;

    assign last_byte = (r_byte >= LastByte);

    // next state
    always_comb begin
        n_step      = r_step;
        n_phase     = r_phase;
        n_bit       = r_bit;
        n_byte      = r_byte;
        n_shift     = r_shift;
        n_is_read   = r_is_read;
        n_held_addr = r_held_addr;
        n_held_data = r_held_data;
        n_scl       = r_scl;
        n_sda       = r_sda;
        last_phase  = (r_phase >= 2'd2);
        go          = 1'b0;
        go_target   = i2cmra_pkg::ST_IDLE;
        rd_valid    = 1'b0;
        rd_data     = 8'd0;
        rd_index    = 4'd0;
        done        = 1'b0;

        if (r_step == i2cmra_pkg::ST_IDLE) begin
            if (i_item.req_type == i2cmra_pkg::REQ_WRITE ||
                i_item.req_type == i2cmra_pkg::REQ_READ) begin
                n_is_read   = (i_item.req_type == i2cmra_pkg::REQ_READ);
                n_held_addr = n_is_read ? i_cfg.read_start_register : i_item.reg_addr;
                n_held_data = n_is_read ? 8'd0 : i_item.wr_data;
                n_byte      = 4'd0;
                go          = 1'b1;
                go_target   = i2cmra_pkg::ST_START;
            end
        end else if (i_item.req_type == i2cmra_pkg::REQ_TICK) begin
            unique case (r_step)
                i2cmra_pkg::ST_START, i2cmra_pkg::ST_RSTART: begin
                    if (r_phase == 2'd0) begin
                        n_sda = 1'b1;
                        n_scl = 1'b1;
                    end else if (r_phase == 2'd1) begin
                        n_sda = 1'b0;
                    end else begin
                        n_scl     = 1'b0;
                        go        = 1'b1;
                        go_target = (r_step == i2cmra_pkg::ST_START) ?
                                    i2cmra_pkg::ST_ADDR_W : i2cmra_pkg::ST_ADDR_R;
                    end
                end
                i2cmra_pkg::ST_ADDR_W, i2cmra_pkg::ST_REG,
                i2cmra_pkg::ST_DATA, i2cmra_pkg::ST_ADDR_R: begin
                    if (r_phase == 2'd0) begin
                        n_scl = 1'b0;
                        n_sda = (r_bit < 4'd8) ? r_shift[7] : 1'b1;
                    end else if (r_phase == 2'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_scl = 1'b0;
                        if (r_bit < 4'd8) begin
                            n_shift = {r_shift[6:0], 1'b0};
                            n_bit   = r_bit + 4'd1;
                            n_phase = 2'd0;
                        end else begin
                            go = 1'b1;
                            unique case (r_step)
                                i2cmra_pkg::ST_ADDR_W: go_target = i2cmra_pkg::ST_REG;
                                i2cmra_pkg::ST_REG:    go_target = r_is_read ?
                                    i2cmra_pkg::ST_RSTART : i2cmra_pkg::ST_DATA;
                                i2cmra_pkg::ST_DATA:   go_target = i2cmra_pkg::ST_STOP;
                                default:               go_target = i2cmra_pkg::ST_RECV;
                            endcase
                        end
                    end
                end
                i2cmra_pkg::ST_RECV: begin
                    if (r_phase == 2'd0) begin
                        n_scl = 1'b0;
                        // master ack on all but the last byte
                        n_sda = (r_bit < 4'd8) ? 1'b1 : last_byte;
                    end else if (r_phase == 2'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_scl = 1'b0;
                        if (r_bit < 4'd8) begin
                            n_shift = {r_shift[6:0], i_item.sda_in};
                            n_bit   = r_bit + 4'd1;
                            n_phase = 2'd0;
                        end else begin
                            rd_valid = 1'b1;
                            rd_data  = r_shift;
                            rd_index = r_byte;
                            if (last_byte) begin
                                go        = 1'b1;
                                go_target = i2cmra_pkg::ST_STOP;
                            end else begin
                                n_byte  = r_byte + 4'd1;
                                n_bit   = 4'd0;
                                n_shift = 8'd0;
                                n_phase = 2'd0;
                            end
                        end
                    end
                end
                i2cmra_pkg::ST_STOP: begin
                    if (r_phase == 2'd0) begin
                        n_scl = 1'b0;
                        n_sda = 1'b0;
                    end else if (r_phase == 2'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_sda   = 1'b1;
                        n_step  = i2cmra_pkg::ST_IDLE;
                        n_phase = 2'd0;
                        done    = 1'b1;
                    end
                end
                default: begin
                    n_step     = i2cmra_pkg::ST_IDLE;
                    n_phase    = 2'd0;
                    last_phase = 1'b1;
                end
            endcase
            if (!last_phase) begin
                n_phase = r_phase + 2'd1;
            end
        end

        // entry into a new step
        if (go) begin
            n_step  = go_target;
            n_phase = 2'd0;
            n_bit   = 4'd0;
            unique case (go_target)
                i2cmra_pkg::ST_ADDR_W: n_shift = {i_cfg.device_address, 1'b0};
                i2cmra_pkg::ST_REG:    n_shift = r_held_addr;
                i2cmra_pkg::ST_DATA:   n_shift = r_held_data;
                i2cmra_pkg::ST_ADDR_R: n_shift = {i_cfg.device_address, 1'b1};
                i2cmra_pkg::ST_RECV: begin
                    n_shift = 8'd0;
                    n_byte  = 4'd0;
                end
                default: ;
            endcase
        end
    end

    // result of this item
    always_comb begin
        o_res.scl        = n_scl;
        o_res.sda_out    = n_sda;
        o_res.busy_res   = (n_step != i2cmra_pkg::ST_IDLE);
        o_res.read_valid = rd_valid;
        o_res.read_data  = rd_data;
        o_res.read_index = rd_index;
        o_res.done_res   = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= i2cmra_pkg::ST_IDLE;
            r_phase     <= 2'd0;
            r_bit       <= 4'd0;
            r_byte      <= 4'd0;
            r_shift     <= 8'd0;
            r_is_read   <= 1'b0;
            r_held_addr <= 8'd0;
            r_held_data <= 8'd0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
        end else if (i_adv) begin
            r_step      <= n_step;
            r_phase     <= n_phase;
            r_bit       <= n_bit;
            r_byte      <= n_byte;
            r_shift     <= n_shift;
            r_is_read   <= n_is_read;
            r_held_addr <= n_held_addr;
            r_held_data <= n_held_data;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
        end
    end

endmodule

@@ hw/rtl/i2c_master_register_access_unit.sv @@
// top level of the i2c master register access unit: ports, config registers, pipeline
// Each input item is one of the three phases of a bus step (a tick) or a command that loads a
// register write or a burst read of READ_BYTES bytes; one result item comes back for
// every input item. The unit takes one item per clock cycle unless o_in_stall holds it, and
// each item passes through an input register, which feeds the phase sequencer, whose outcome is
// caught in a result register. A held result does not block intake until both registers
// are full. Commands are taken only when the bus is idle; otherwise they are answered with
// the current line levels. Configuration registers: device_address at byte 0, and
// read_start_register at byte 4.
module i2c_master_register_access_unit #(
    parameter int READ_BYTES = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  i2cmra_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output i2cmra_pkg::t_out_item o_out_item
);

    i2cmra_pkg::t_cfg      r_cfg;
    logic                  r_in_valid;
    i2cmra_pkg::t_in_item  r_in_item;
    logic                  r_out_valid;
    i2cmra_pkg::t_out_item r_out_item;
    i2cmra_pkg::t_out_item seq_res;
    logic                  out_free;
    logic                  adv;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address      <= i2cmra_pkg::DEVICE_ADDRESS_RESET;
            r_cfg.read_start_register <= i2cmra_pkg::READ_START_REGISTER_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                i2cmra_pkg::REG_DEVICE_ADDRESS:
                    r_cfg.device_address <= pwdata[6:0];
                i2cmra_pkg::REG_READ_START_REGISTER:
                    r_cfg.read_start_register <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            i2cmra_pkg::REG_DEVICE_ADDRESS:
                prdata = {25'd0, r_cfg.device_address};
            i2cmra_pkg::REG_READ_START_REGISTER:
                prdata = {24'd0, r_cfg.read_start_register};
            default:
                prdata = 32'd0;
        endcase
    end

    // an item moves into the sequencer when the result register can take its outcome
    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    i2cmra_seq #(
        .READ_BYTES (READ_BYTES)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in_item),
        .i_cfg   (r_cfg),
        .o_res   (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_item <= seq_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
